// File: rtl/core/heg_pkg.sv
package heg_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int RunMax = 6;
    localparam int IdxW   = $clog2(RunMax);

    localparam logic [7:0] ChAmp  = 8'h26;
    localparam logic [7:0] ChHash = 8'h23;
    localparam logic [7:0] ChSemi = 8'h3B;
    localparam logic [7:0] ChSp   = 8'h20;
    localparam logic [7:0] ChZero = 8'h30;
    localparam logic [7:0] ChLt   = 8'h3C;
    localparam logic [7:0] ChGt   = 8'h3E;
    localparam logic [7:0] ChQuot = 8'h22;
    localparam logic [7:0] ChApos = 8'h27;
    localparam logic [7:0] ChTab  = 8'h09;
    localparam logic [7:0] ChLf   = 8'h0A;
    localparam logic [7:0] ChCr   = 8'h0D;

    // bytes[0] goes out first
    typedef struct packed {
        logic [IdxW-1:0]            len_m1;
        logic [RunMax-1:0][7:0]     bytes;
    } heg_run_t;

endpackage

// File: rtl/core/heg_front.sv
module heg_front import heg_pkg::*; (
    input  logic [7:0] in_byte,
    output heg_run_t   run
);

    logic [1:0] hund;
    logic [7:0] rem8;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [3:0] tens;
    logic [7:0] tens_x10;
    logic [3:0] units;
    logic [7:0] h_ch;
    logic [7:0] t_ch;

    always_comb begin
        if (in_byte >= 8'd200) begin
            hund = 2'd2;
            rem8 = in_byte - 8'd200;
        end else if (in_byte >= 8'd100) begin
            hund = 2'd1;
            rem8 = in_byte - 8'd100;
        end else begin
            hund = 2'd0;
            rem8 = in_byte;
        end
        rem      = rem8[6:0];
        // x / 10 == (x * 205) >> 11 for x < 100
        prod     = 15'(rem) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {4'd0, tens} * 8'd10;
        units    = 4'(rem8 - tens_x10);
        h_ch     = (hund != 2'd0) ? (ChZero + {6'd0, hund}) : ChSp;
        t_ch     = (hund != 2'd0 || tens != 4'd0) ? (ChZero + {4'd0, tens}) : ChSp;
    end

    always_comb begin
        run.bytes  = '0;
        run.len_m1 = '0;
        case (in_byte)
            ChLt: begin
                run.bytes[0] = ChAmp; run.bytes[1] = 8'h6C;
                run.bytes[2] = 8'h74; run.bytes[3] = ChSemi;
                run.len_m1   = IdxW'(3);
            end
            ChGt: begin
                run.bytes[0] = ChAmp; run.bytes[1] = 8'h67;
                run.bytes[2] = 8'h74; run.bytes[3] = ChSemi;
                run.len_m1   = IdxW'(3);
            end
            ChQuot: begin
                run.bytes[0] = ChAmp; run.bytes[1] = 8'h71;
                run.bytes[2] = 8'h75; run.bytes[3] = 8'h6F;
                run.bytes[4] = 8'h74; run.bytes[5] = ChSemi;
                run.len_m1   = IdxW'(5);
            end
            ChAmp: begin
                run.bytes[0] = ChAmp; run.bytes[1] = 8'h61;
                run.bytes[2] = 8'h6D; run.bytes[3] = 8'h70;
                run.bytes[4] = ChSemi;
                run.len_m1   = IdxW'(4);
            end
            ChApos: begin
                run.bytes[0] = ChAmp; run.bytes[1] = ChHash;
                run.bytes[2] = 8'h33; run.bytes[3] = 8'h39;
                run.bytes[4] = ChSemi;
                run.len_m1   = IdxW'(4);
            end
            default: begin
                if ((in_byte inside {[8'h00:8'h1F], [8'h7F:8'hFF]})
                    && !(in_byte inside {ChTab, ChLf, ChCr})) begin
                    run.bytes[0] = ChAmp;
                    run.bytes[1] = ChHash;
                    run.bytes[2] = h_ch;
                    run.bytes[3] = t_ch;
                    run.bytes[4] = ChZero + {4'd0, units};
                    run.bytes[5] = ChSemi;
                    run.len_m1   = IdxW'(5);
                end else begin
                    run.bytes[0] = in_byte;
                    run.len_m1   = '0;
                end
            end
        endcase
    end

endmodule

// File: rtl/core/heg_queue.sv
module heg_queue import heg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  heg_run_t push_data,
    output logic     full,
    input  logic     pop,
    output heg_run_t head,
    output logic     empty
);

    heg_run_t       mem_reg [QDepth];
    logic [QAw-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAw-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAw:0]   count_reg, count_next;

    assign full  = (count_reg == (QAw+1)'(QDepth));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAw+1)'(push) - (QAw+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/heg_back.sv
module heg_back import heg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  heg_run_t   head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);

    logic [IdxW-1:0] idx_reg, idx_next;
    logic            valid_reg, valid_next;
    logic [7:0]      byte_reg;
    logic            last_reg;
    logic            load;
    logic            at_end;

    assign load   = !empty && (!valid_reg || m_ready);
    assign at_end = (idx_reg == head.len_m1);
    assign pop    = load && at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = at_end ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= at_end;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

// File: rtl/core/html_entity_escaper.sv
// HTML entity escaper. Each input byte becomes a run of one to six output
// bytes, the final one flagged by m_last_of_run: markup characters turn into
// named or numeric entities, control and high bytes (other than tab, newline
// and carriage return) into "&#ddd;" with space padding, all else passes as is.
// Output runs at one byte per cycle while m_ready is high, so a longer run
// holds the output longer. A four-entry queue of classified runs sits
// between the input classifier and the output sequencer, so input keeps
// flowing while a long run drains, until the queue fills. An input byte
// reaches the output through a queue entry and the output byte register.
module html_entity_escaper import heg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);

    heg_run_t run;
    heg_run_t head;
    logic     full;
    logic     empty;
    logic     pop;
    logic     push;

    assign s_ready = !full;
    assign push    = s_valid && !full;

    heg_front u_front (
        .in_byte (s_in_byte),
        .run     (run)
    );

    heg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (run),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    heg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import heg_pkg::*;

    localparam int RandomRequests = 420;
    localparam int CalmTail       = 70;
    localparam int QuietLimit     = 2000;
    localparam int TailCycles     = 20;

    class escape_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } escaped_t;

        escaped_t escaped_q[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        function void push_text(string txt);
            escaped_t e;
            for (int i = 0; i < txt.len(); i++) begin
                e.ch   = txt[i];
                e.last = (i == txt.len() - 1);
                escaped_q.push_back(e);
            end
        endfunction

        function void push_numeric(logic [7:0] c);
            int        hund;
            int        tens;
            int        unit;
            escaped_t  e;
            logic [7:0] run [6];
            hund   = c / 100;
            tens   = (c / 10) % 10;
            unit   = c % 10;
            run[0] = ChAmp;
            run[1] = ChHash;
            run[2] = (hund != 0) ? ChZero + 8'(hund) : ChSp;
            run[3] = (hund != 0 || tens != 0) ? ChZero + 8'(tens) : ChSp;
            run[4] = ChZero + 8'(unit);
            run[5] = ChSemi;
            for (int i = 0; i < 6; i++) begin
                e.ch   = run[i];
                e.last = (i == 5);
                escaped_q.push_back(e);
            end
        endfunction

        // expected run for one accepted request
        function void note_request(logic [7:0] c);
            escaped_t e;
            case (c)
                ChLt:   push_text("&lt;");
                ChGt:   push_text("&gt;");
                ChQuot: push_text("&quot;");
                ChAmp:  push_text("&amp;");
                ChApos: push_text("&#39;");
                ChTab, ChLf, ChCr: begin
                    e.ch   = c;
                    e.last = 1'b1;
                    escaped_q.push_back(e);
                end
                default: begin
                    if (c <= 8'h1F || c >= 8'h7F) begin
                        push_numeric(c);
                    end else begin
                        e.ch   = c;
                        e.last = 1'b1;
                        escaped_q.push_back(e);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [7:0] ch, logic last);
            escaped_t e;
            if (escaped_q.size() == 0) begin
                $error("unexpected output byte %h (last %b)", ch, last);
                errors++;
                return;
            end
            e = escaped_q.pop_front();
            if (ch !== e.ch) begin
                $error("out_byte: expected %h, got %h", e.ch, ch);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_of_run: expected %b, got %b", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return escaped_q.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    escape_scoreboard sb = new();
    bit               idle_on = 1'b1;
    int               quiet_cycles = 0;
    int unsigned      ready_hold;
    logic [7:0]       markup [5] = '{ChLt, ChGt, ChQuot, ChAmp, ChApos};
    logic [7:0]       directed [24] = '{
        8'h00, ChTab, ChLf, ChCr, 8'h05, 8'h0B, 8'h1F, 8'h20,
        ChLt, ChGt, ChQuot, ChAmp, ChApos, 8'h41, 8'h64, 8'h7E,
        8'h7F, 8'h80, 8'hC8, 8'hFF, ChAmp, ChLt, 8'h01, 8'hAA
    };

    html_entity_escaper u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_in_byte);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_out_byte, m_last_of_run);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QuietLimit) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: stall bursts while idling is on
    always begin
        if (idle_on && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            ready_hold  = $urandom_range(1, 19);
        end else begin
            m_ready    <= 1'b1;
            ready_hold  = $urandom_range(1, 24);
        end
        repeat (ready_hold) @(negedge aclk);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(logic [7:0] c, int unsigned gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= c;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] random_text_byte();
        case ($urandom_range(0, 9))
            0, 1:    return markup[$urandom_range(0, 4)];
            2, 3, 4: return 8'($urandom_range(8'h20, 8'h7E));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int unsigned gap;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
            send_request(directed[i], gap);
        end
        drain_results();

        for (int i = 0; i < RandomRequests; i++) begin
            if (i == RandomRequests / 2) begin
                drain_results();
            end
            if (i == RandomRequests - CalmTail) begin
                idle_on = 1'b0;
            end
            gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
            send_request(random_text_byte(), gap);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
